>>> rtl/fdr_pkg.sv
// Package: shared constants and types of the finger dropout hold and recover filter.
`timescale 1ns / 1ps
package fdr_pkg;

  localparam int FINGER_COUNT = 5;
  localparam int FIDX_W       = $clog2(FINGER_COUNT);

  localparam logic [62:0] T63_MAX   = 63'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [31:0] NS_PER_S  = 32'd1_000_000_000;
  localparam logic [16:0] STEP_LIM  = 17'd65536;
  localparam logic [16:0] CONF_LIM  = 17'd16384;
  localparam logic [15:0] CONF_ONE  = 16'sd16384;

  // Products at or above these give an amount that saturates at the limit.
  localparam logic [63:0] STEP_NS   = 64'd65536000000000;
  localparam logic [63:0] CONF_NS   = 64'd16384000000000;
  // floor(2^61 / one second in nanoseconds), for the reciprocal quotient estimate.
  localparam logic [31:0] RECIP     = 32'd2305843009;

  // Configuration register indexes.
  localparam logic [2:0] REG_HELD_DUR = 3'd0;
  localparam logic [2:0] REG_RET_DUR  = 3'd1;
  localparam logic [2:0] REG_REC_DUR  = 3'd2;
  localparam logic [2:0] REG_DECAY    = 3'd3;
  localparam logic [2:0] REG_REC_RATE = 3'd4;

  // Result source codes.
  localparam logic [1:0] SRC_EST  = 2'd0;
  localparam logic [1:0] SRC_HELD = 2'd1;
  localparam logic [1:0] SRC_REC  = 2'd2;

  typedef logic signed [15:0] ang_t;

  // One finger's stored state.
  typedef struct packed {
    ang_t [2:0]  pose;
    logic [14:0] conf;
    logic [62:0] lvt;
    logic [62:0] dl;
    logic        has;
    logic        held;
  } ent_t;

endpackage

>>> rtl/fdr_div.sv
// Module: restoring divider, one quotient bit per cycle, 64-bit dividend by 32-bit divisor.
`timescale 1ns / 1ps
module fdr_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [63:0] quotient
);

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [63:0] quo_r, quo_nxt;
  logic [31:0] dvs_r, dvs_nxt;
  logic [32:0] rem_sh;
  logic [33:0] trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    rem_sh   = {rem_r[31:0], quo_r[63]};
    trial    = {1'b0, rem_sh} - {2'b00, dvs_r};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      if (!trial[33]) begin
        rem_nxt = trial[32:0];
        quo_nxt = {quo_r[62:0], 1'b1};
      end else begin
        rem_nxt = rem_sh;
        quo_nxt = {quo_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'd63) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

>>> rtl/fdr_mem.sv
// Module: per-finger state memory with registered read and per-entry valid bits.
`timescale 1ns / 1ps
module fdr_mem (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      rd_en,
  input  logic [fdr_pkg::FIDX_W-1:0] rd_addr,
  output fdr_pkg::ent_t             rd_data,
  input  logic                      wr_en,
  input  logic [fdr_pkg::FIDX_W-1:0] wr_addr,
  input  fdr_pkg::ent_t             wr_data
);

  fdr_pkg::ent_t                     mem [fdr_pkg::FINGER_COUNT];
  logic [fdr_pkg::FINGER_COUNT-1:0]  vld_r;
  fdr_pkg::ent_t                     rd_r;
  logic                              rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_r     <= mem[rd_addr];
      rd_vld_r <= vld_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  // An entry never written reads as the all-zero reset state.
  assign rd_data = rd_vld_r ? rd_r : '0;

endmodule

>>> rtl/finger_dropout_hold_recover_filter.sv
// Module: top level of the finger dropout hold and recover filter.
`timescale 1ns / 1ps
// Usage
// One observation of one finger enters as a transaction on the in_ channel
// (valid/ready); one result transaction leaves on the out_ channel for each.
// The cfg_ port writes one of the five timing and rate registers at a time;
// write them only while the block is idle.
// Each finger's state sits in a five-entry memory. An item is read from it,
// worked on by a small sequencer and written back before the next item is
// taken, so one item is handled at a time.
// An out-of-range finger goes straight to the write-back state; a plain valid
// sample or a missing sample before any pose first passes one evaluation
// state; a catch-up or a confidence decay then adds a two-part multiply, a
// reciprocal multiplication for the division by one second and one
// correction step, the later steps being skipped when the amount saturates;
// a decay that also scales the pose towards zero adds three 64-step serial
// divisions by the return duration.
// The result lands in an output register, and the block takes the next
// transaction while it waits; a stall on out_ready only holds the block once
// a second result is ready to leave.
// Reset is synchronous and active low: all fingers read as zero state, the
// registers return to their defaults, and no result is pending.
module finger_dropout_hold_recover_filter (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_finger,
  input  logic               in_sample_ok,
  input  logic signed [15:0] in_flexion_in,
  input  logic signed [15:0] in_abduction_in,
  input  logic signed [15:0] in_twist_in,
  input  logic signed [15:0] in_confidence_in,
  input  logic [62:0]        in_time_ns,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_finger_out,
  output logic signed [15:0] out_flexion_out,
  output logic signed [15:0] out_abduction_out,
  output logic signed [15:0] out_twist_out,
  output logic [14:0]        out_confidence_out,
  output logic [1:0]         out_source,
  output logic               out_pose_known
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_EVAL  = 4'd1;
  localparam logic [3:0] S_MUL1  = 4'd2;
  localparam logic [3:0] S_MUL2  = 4'd3;
  localparam logic [3:0] S_RGO   = 4'd4;
  localparam logic [3:0] S_RWAIT = 4'd5;
  localparam logic [3:0] S_APPLY = 4'd6;
  localparam logic [3:0] S_SMUL  = 4'd7;
  localparam logic [3:0] S_SGO   = 4'd8;
  localparam logic [3:0] S_SWAIT = 4'd9;
  localparam logic [3:0] S_WR    = 4'd10;
  localparam logic [3:0] S_RFIX  = 4'd11;

  // Configuration registers.
  logic [31:0] held_dur_r, ret_dur_r, rec_dur_r;
  logic [15:0] decay_r, rec_rate_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_dur_r <= 32'd150000000;
      ret_dur_r  <= 32'd350000000;
      rec_dur_r  <= 32'd200000000;
      decay_r    <= 16'd13107;
      rec_rate_r <= 16'd23040;
    end else if (cfg_we) begin
      case (cfg_index)
        fdr_pkg::REG_HELD_DUR: held_dur_r <= cfg_wdata;
        fdr_pkg::REG_RET_DUR:  ret_dur_r  <= cfg_wdata;
        fdr_pkg::REG_REC_DUR:  rec_dur_r  <= cfg_wdata;
        fdr_pkg::REG_DECAY:    decay_r    <= cfg_wdata[15:0];
        fdr_pkg::REG_REC_RATE: rec_rate_r <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // Sequencer and working registers.
  logic [3:0]                state_r, state_nxt;
  logic [2:0]                fin_r, fin_nxt;
  logic                      ok_r, ok_nxt;
  logic                      zero_r, zero_nxt;
  fdr_pkg::ang_t [2:0]       tgt_r, tgt_nxt;
  logic signed [15:0]        cin_r, cin_nxt;
  logic [62:0]               t_r, t_nxt;
  fdr_pkg::ent_t             ent_r, ent_nxt;
  logic [62:0]               el_r, el_nxt;
  logic [63:0]               prod_r, prod_nxt;
  logic [16:0]               amt_r, amt_nxt;
  logic [31:0]               keep_r, keep_nxt;
  logic [1:0]                k_r, k_nxt;
  logic                      neg_r, neg_nxt;

  logic                      out_valid_r, out_valid_nxt;
  logic [2:0]                o_fin_r, o_fin_nxt;
  fdr_pkg::ang_t [2:0]       o_pose_r, o_pose_nxt;
  logic [14:0]               o_conf_r, o_conf_nxt;
  logic [1:0]                o_src_r, o_src_nxt;
  logic                      o_known_r, o_known_nxt;

  // Memory and divider connections.
  logic                        rd_en, wr_en;
  logic [fdr_pkg::FIDX_W-1:0]  rd_addr, wr_addr;
  fdr_pkg::ent_t               rd_data;
  logic                        div_start, div_done;
  logic [63:0]                 div_dividend, div_quot;
  logic [31:0]                 div_divisor;

  fdr_mem u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (ent_r)
  );

  fdr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quot)
  );

  logic               in_acc;
  logic               in_range;
  logic [15:0]        rate_sel;
  logic [16:0]        lim_sel;
  logic [63:0]        lim_ns;
  logic [63:0]        rcp_prod;
  logic [62:0]        x_el;
  logic [63:0]        dl_sum;
  logic signed [17:0] d_diff, stp, new_ang;
  logic [16:0]        mag17;
  logic [15:0]        q16;
  logic [1:0]         src_v;

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign in_range = ({1'b0, in_finger} < 4'(fdr_pkg::FINGER_COUNT));
  assign rd_en    = in_acc && in_range;
  assign rd_addr  = in_finger[fdr_pkg::FIDX_W-1:0];
  assign wr_addr  = fin_r[fdr_pkg::FIDX_W-1:0];
  assign rate_sel = ok_r ? rec_rate_r : decay_r;
  assign lim_sel  = ok_r ? fdr_pkg::STEP_LIM : fdr_pkg::CONF_LIM;
  assign lim_ns   = ok_r ? fdr_pkg::STEP_NS : fdr_pkg::CONF_NS;
  assign x_el     = el_r - {31'd0, held_dur_r};
  assign dl_sum   = {1'b0, t_r} + {32'd0, rec_dur_r};

  // Below the saturation point the product fits in 46 bits, so its top 32 bits
  // times the reciprocal give the quotient, at most one below the true value.
  assign rcp_prod = {32'd0, prod_r[45:14]} * {32'd0, fdr_pkg::RECIP};

  always_comb begin
    state_nxt     = state_r;
    fin_nxt       = fin_r;
    ok_nxt        = ok_r;
    zero_nxt      = zero_r;
    tgt_nxt       = tgt_r;
    cin_nxt       = cin_r;
    t_nxt         = t_r;
    ent_nxt       = ent_r;
    el_nxt        = el_r;
    prod_nxt      = prod_r;
    amt_nxt       = amt_r;
    keep_nxt      = keep_r;
    k_nxt         = k_r;
    neg_nxt       = neg_r;
    out_valid_nxt = out_valid_r;
    o_fin_nxt     = o_fin_r;
    o_pose_nxt    = o_pose_r;
    o_conf_nxt    = o_conf_r;
    o_src_nxt     = o_src_r;
    o_known_nxt   = o_known_r;
    wr_en         = 1'b0;
    div_start     = 1'b0;
    div_dividend  = prod_r;
    div_divisor   = ret_dur_r;
    d_diff        = '0;
    stp           = '0;
    new_ang       = '0;
    mag17         = '0;
    q16           = div_quot[15:0];
    src_v         = fdr_pkg::SRC_EST;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          fin_nxt  = in_finger;
          ok_nxt   = in_sample_ok;
          zero_nxt = !in_range;
          tgt_nxt  = {in_twist_in, in_abduction_in, in_flexion_in};
          cin_nxt  = in_confidence_in;
          t_nxt    = in_time_ns;
          state_nxt = in_range ? S_EVAL : S_WR;
        end
      end
      S_EVAL: begin
        ent_nxt = rd_data;
        if (ok_r) begin
          if (rd_data.held && rd_data.has && (t_r > rd_data.lvt)) begin
            el_nxt    = t_r - rd_data.lvt;
            state_nxt = S_MUL1;
          end else begin
            // Plain valid sample: the target is taken directly.
            ent_nxt.pose = tgt_r;
            ent_nxt.lvt  = t_r;
            ent_nxt.conf = cin_r[15] ? 15'd0 :
                           (cin_r > fdr_pkg::CONF_ONE) ? 15'd16384 : cin_r[14:0];
            ent_nxt.has  = 1'b1;
            ent_nxt.held = 1'b0;
            state_nxt    = S_WR;
          end
        end else if (rd_data.has) begin
          el_nxt    = (t_r > rd_data.lvt) ? (t_r - rd_data.lvt) : '0;
          state_nxt = S_MUL1;
        end else begin
          state_nxt = S_WR;
        end
      end
      S_MUL1: begin
        if (el_r[62:48] != '0) begin
          amt_nxt   = (rate_sel != '0) ? lim_sel : '0;
          state_nxt = S_APPLY;
        end else begin
          prod_nxt  = {24'd0, {24'd0, rate_sel} * {16'd0, el_r[23:0]}};
          state_nxt = S_MUL2;
        end
      end
      S_MUL2: begin
        prod_nxt  = prod_r + {{24'd0, rate_sel} * {16'd0, el_r[47:24]}, 24'd0};
        state_nxt = S_RGO;
      end
      S_RGO: begin
        if (prod_r >= lim_ns) begin
          amt_nxt   = lim_sel;
          state_nxt = S_APPLY;
        end else begin
          amt_nxt   = rcp_prod[63:47];
          state_nxt = S_RWAIT;
        end
      end
      S_RWAIT: begin
        // Remainder of the estimate, used to correct it by one.
        prod_nxt  = prod_r - {17'd0, {30'd0, amt_r} * {15'd0, fdr_pkg::NS_PER_S}};
        state_nxt = S_RFIX;
      end
      S_RFIX: begin
        if (prod_r >= {32'd0, fdr_pkg::NS_PER_S}) begin
          amt_nxt = amt_r + 17'd1;
        end
        state_nxt = S_APPLY;
      end
      S_APPLY: begin
        if (ok_r) begin
          // Catch-up after a hold: each angle moves by at most the step.
          stp = {1'b0, amt_r};
          for (int i = 0; i < 3; i++) begin
            d_diff = 18'(tgt_r[i]) - 18'(ent_r.pose[i]);
            if (d_diff > stp) d_diff = stp;
            if (d_diff < -stp) d_diff = -stp;
            new_ang = 18'(ent_r.pose[i]) + d_diff;
            ent_nxt.pose[i] = new_ang[15:0];
          end
          ent_nxt.dl   = dl_sum[63] ? fdr_pkg::T63_MAX : dl_sum[62:0];
          ent_nxt.lvt  = t_r;
          ent_nxt.conf = cin_r[15] ? 15'd0 :
                         (cin_r > fdr_pkg::CONF_ONE) ? 15'd16384 : cin_r[14:0];
          ent_nxt.has  = 1'b1;
          ent_nxt.held = 1'b0;
          state_nxt    = S_WR;
        end else begin
          ent_nxt.held = 1'b1;
          ent_nxt.conf = (amt_r >= {2'b00, ent_r.conf}) ? 15'd0 :
                         (ent_r.conf - amt_r[14:0]);
          state_nxt    = S_WR;
          if (el_r > {31'd0, held_dur_r}) begin
            if (x_el >= {31'd0, ret_dur_r}) begin
              ent_nxt.pose = '0;
            end else begin
              keep_nxt  = ret_dur_r - x_el[31:0];
              k_nxt     = '0;
              state_nxt = S_SMUL;
            end
          end
        end
      end
      S_SMUL: begin
        mag17     = ent_r.pose[k_r][15] ? (17'd0 - 17'(ent_r.pose[k_r]))
                                        : 17'(ent_r.pose[k_r]);
        neg_nxt   = ent_r.pose[k_r][15];
        prod_nxt  = {16'd0, {32'd0, mag17[15:0]} * {16'd0, keep_r}};
        state_nxt = S_SGO;
      end
      S_SGO: begin
        div_start = 1'b1;
        state_nxt = S_SWAIT;
      end
      S_SWAIT: begin
        if (div_done) begin
          ent_nxt.pose[k_r] = neg_r ? (16'd0 - q16) : q16;
          if (k_r == 2'd2) begin
            state_nxt = S_WR;
          end else begin
            k_nxt     = k_r + 2'd1;
            state_nxt = S_SMUL;
          end
        end
      end
      S_WR: begin
        // Wait here only while an earlier result still occupies the output.
        if (!out_valid_r || out_ready) begin
          wr_en         = !zero_r;
          out_valid_nxt = 1'b1;
          o_fin_nxt     = fin_r;
          if (zero_r) begin
            o_pose_nxt  = '0;
            o_conf_nxt  = '0;
            o_src_nxt   = fdr_pkg::SRC_EST;
            o_known_nxt = 1'b0;
          end else begin
            if (ent_r.held) src_v = fdr_pkg::SRC_HELD;
            else if (t_r <= ent_r.dl) src_v = fdr_pkg::SRC_REC;
            o_pose_nxt  = ent_r.pose;
            o_conf_nxt  = ent_r.conf;
            o_src_nxt   = src_v;
            o_known_nxt = ent_r.has;
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    fin_r     <= fin_nxt;
    ok_r      <= ok_nxt;
    zero_r    <= zero_nxt;
    tgt_r     <= tgt_nxt;
    cin_r     <= cin_nxt;
    t_r       <= t_nxt;
    ent_r     <= ent_nxt;
    el_r      <= el_nxt;
    prod_r    <= prod_nxt;
    amt_r     <= amt_nxt;
    keep_r    <= keep_nxt;
    k_r       <= k_nxt;
    neg_r     <= neg_nxt;
    o_fin_r   <= o_fin_nxt;
    o_pose_r  <= o_pose_nxt;
    o_conf_r  <= o_conf_nxt;
    o_src_r   <= o_src_nxt;
    o_known_r <= o_known_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_finger_out     = o_fin_r;
  assign out_flexion_out    = o_pose_r[0];
  assign out_abduction_out  = o_pose_r[1];
  assign out_twist_out      = o_pose_r[2];
  assign out_confidence_out = o_conf_r;
  assign out_source         = o_src_r;
  assign out_pose_known     = o_known_r;

endmodule

>>> bench/finger_dropout_hold_recover_filter_tb.sv
// Testbench: self-checking bench for the finger dropout hold and recover filter.
`timescale 1ns / 1ps
module finger_dropout_hold_recover_filter_tb;

  localparam int NF = 5;
  localparam logic [62:0] T_MAX = 63'h7FFF_FFFF_FFFF_FFFF;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [2:0]         cfg_index = '0;
  logic [31:0]        cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [2:0]         in_finger = '0;
  logic               in_sample_ok = 1'b0;
  logic signed [15:0] in_flexion_in = '0;
  logic signed [15:0] in_abduction_in = '0;
  logic signed [15:0] in_twist_in = '0;
  logic signed [15:0] in_confidence_in = '0;
  logic [62:0]        in_time_ns = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [2:0]         out_finger_out;
  logic signed [15:0] out_flexion_out;
  logic signed [15:0] out_abduction_out;
  logic signed [15:0] out_twist_out;
  logic [14:0]        out_confidence_out;
  logic [1:0]         out_source;
  logic               out_pose_known;

  finger_dropout_hold_recover_filter dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // One expected result transaction.
  typedef struct packed {
    logic [2:0]         fing;
    logic signed [15:0] flex;
    logic signed [15:0] abd;
    logic signed [15:0] twi;
    logic [14:0]        conf;
    logic [1:0]         src;
    logic               known;
  } pose_res_t;

  pose_res_t pending_poses[$];

  // Predictor copy of the per-finger state and the registers.
  logic signed [31:0] m_pose[NF][3];
  logic [14:0]        m_conf[NF];
  logic [62:0]        m_lvt[NF];
  logic [62:0]        m_dl[NF];
  logic               m_has[NF];
  logic               m_held[NF];
  logic [31:0]        r_held, r_ret, r_rec;
  logic [15:0]        r_decay, r_rate;

  int mismatches = 0;
  int results_seen = 0;
  int items_sent = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  logic [62:0] clock_ns [NF];

  function automatic void model_reset();
    for (int f = 0; f < NF; f++) begin
      for (int k = 0; k < 3; k++) m_pose[f][k] = 32'sd0;
      m_conf[f] = '0; m_lvt[f] = '0; m_dl[f] = '0;
      m_has[f] = 1'b0; m_held[f] = 1'b0;
    end
    r_held = 32'd150000000; r_ret = 32'd350000000; r_rec = 32'd200000000;
    r_decay = 16'd13107; r_rate = 16'd23040;
  endfunction

  // floor(rate * elapsed / one second), capped at lim.
  function automatic logic [63:0] rate_scaled(logic [15:0] rate, logic [62:0] el,
                                              logic [63:0] lim);
    logic [127:0] q;
    if (el >= 63'h1_0000_0000_0000) return (rate != 0) ? lim : 64'd0;
    q = (128'(rate) * 128'(el)) / 128'd1000000000;
    return (q > 128'(lim)) ? lim : q[63:0];
  endfunction

  function automatic logic signed [31:0] shrink_angle(logic signed [31:0] a,
                                                      logic [63:0] keep, logic [63:0] whole);
    logic [63:0] mag;
    logic [63:0] r;
    mag = (a < 0) ? 64'(-a) : 64'(a);
    r = (mag * keep) / whole;
    return (a < 0) ? -$signed(32'(r)) : $signed(32'(r));
  endfunction

  function automatic pose_res_t predict_pose(logic [2:0] fin, logic ok,
                                             logic signed [15:0] tg[3],
                                             logic signed [15:0] cin, logic [62:0] t);
    pose_res_t res;
    logic [63:0] step, dec, x, el;
    logic [63:0] dl;
    logic signed [63:0] d;
    res = '0;
    res.fing = fin;
    if (fin >= NF) return res;
    if (ok) begin
      if (m_held[fin] && m_has[fin] && t > m_lvt[fin]) begin
        step = rate_scaled(r_rate, t - m_lvt[fin], 64'd65536);
        for (int k = 0; k < 3; k++) begin
          d = 64'(tg[k]) - 64'(m_pose[fin][k]);
          if (d > $signed(step)) d = step;
          if (d < -$signed(step)) d = -$signed(step);
          m_pose[fin][k] = m_pose[fin][k] + 32'(d);
        end
        dl = 64'(t) + 64'(r_rec);
        m_dl[fin] = (dl > 64'(T_MAX)) ? T_MAX : dl[62:0];
      end else begin
        for (int k = 0; k < 3; k++) m_pose[fin][k] = 32'(tg[k]);
      end
      m_lvt[fin] = t;
      m_conf[fin] = (cin < 0) ? 15'd0 : (cin > 16384 ? 15'd16384 : cin[14:0]);
      m_has[fin] = 1'b1;
      m_held[fin] = 1'b0;
    end else if (m_has[fin]) begin
      el = (t > m_lvt[fin]) ? 64'(t - m_lvt[fin]) : 64'd0;
      dec = rate_scaled(r_decay, el[62:0], 64'd16384);
      m_held[fin] = 1'b1;
      m_conf[fin] = (dec >= 64'(m_conf[fin])) ? 15'd0 : m_conf[fin] - dec[14:0];
      if (el > 64'(r_held)) begin
        x = el - 64'(r_held);
        for (int k = 0; k < 3; k++)
          m_pose[fin][k] = (x >= 64'(r_ret)) ? 32'sd0
                         : shrink_angle(m_pose[fin][k], 64'(r_ret) - x, 64'(r_ret));
      end
    end
    res.flex = m_pose[fin][0][15:0];
    res.abd = m_pose[fin][1][15:0];
    res.twi = m_pose[fin][2][15:0];
    res.conf = m_conf[fin];
    res.src = m_held[fin] ? fdr_pkg::SRC_HELD
                          : (t <= m_dl[fin] ? fdr_pkg::SRC_REC : fdr_pkg::SRC_EST);
    res.known = m_has[fin];
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    mismatches++;
    $display("MISMATCH %s: got %0h expected %0h", what, got, want);
  endtask

  // Sends one observation, holding it until the block accepts the transaction.
  // Valid stays high after acceptance; the next call either drives a new
  // observation or drops valid in that same time step.
  task automatic send_sample(logic [2:0] fin, logic ok, logic signed [15:0] a0,
                             logic signed [15:0] a1, logic signed [15:0] a2,
                             logic signed [15:0] cin, logic [62:0] t);
    logic signed [15:0] tg[3];
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    tg[0] = a0; tg[1] = a1; tg[2] = a2;
    pending_poses.push_back(predict_pose(fin, ok, tg, cin, t));
    in_valid <= 1'b1; in_finger <= fin; in_sample_ok <= ok;
    in_flexion_in <= a0; in_abduction_in <= a1; in_twist_in <= a2;
    in_confidence_in <= cin; in_time_ns <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  // Registers are only written with the block idle: the task drops valid and
  // waits until every predicted result has been received before the write.
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    in_valid <= 1'b0;
    while (pending_poses.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      fdr_pkg::REG_HELD_DUR: r_held = val;
      fdr_pkg::REG_RET_DUR:  r_ret = val;
      fdr_pkg::REG_REC_DUR:  r_rec = val;
      fdr_pkg::REG_DECAY:    r_decay = val[15:0];
      fdr_pkg::REG_REC_RATE: r_rate = val[15:0];
      default: ;
    endcase
  endtask

  // Result checker: the receiver stalls at random, and every accepted result
  // is compared field by field with the oldest prediction.
  always @(posedge clk) begin
    pose_res_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (pending_poses.size() == 0) begin
        report_mismatch("unexpected result", 64'(out_finger_out), 64'd0);
      end else begin
        want = pending_poses.pop_front();
        if (out_finger_out !== want.fing)
          report_mismatch("finger", 64'(out_finger_out), 64'(want.fing));
        if (out_flexion_out !== want.flex)
          report_mismatch("flexion", 64'(out_flexion_out), 64'(want.flex));
        if (out_abduction_out !== want.abd)
          report_mismatch("abduction", 64'(out_abduction_out), 64'(want.abd));
        if (out_twist_out !== want.twi)
          report_mismatch("twist", 64'(out_twist_out), 64'(want.twi));
        if (out_confidence_out !== want.conf)
          report_mismatch("confidence", 64'(out_confidence_out), 64'(want.conf));
        if (out_source !== want.src)
          report_mismatch("source", 64'(out_source), 64'(want.src));
        if (out_pose_known !== want.known)
          report_mismatch("pose known", 64'(out_pose_known), 64'(want.known));
      end
    end
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic logic signed [15:0] rand_angle();
    case ($urandom_range(5))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return $signed(16'($urandom_range(400))) - 16'sd200;
      default: return 16'($urandom);
    endcase
  endfunction

  // Elapsed time mostly in the range where hold, return and catch-up matter.
  function automatic logic [62:0] rand_advance();
    case ($urandom_range(9))
      0: return 63'd0;
      1: return 63'($urandom_range(2000));
      2: return 63'({$urandom, $urandom}) & 63'h7FFF_FFFF_FFFF;
      default: return 63'($urandom_range(900000000));
    endcase
  endfunction

  task automatic test_directed();
    // A missing sample before any pose, and two out-of-range fingers.
    send_sample(3'd0, 1'b0, 16'sd100, 16'sd0, 16'sd0, 16'sd0, 63'd0);
    send_sample(3'd5, 1'b1, 16'sd1, 16'sd2, 16'sd3, 16'sd4, 63'd10);
    send_sample(3'd7, 1'b0, -16'sd1, -16'sd1, -16'sd1, -16'sd1, T_MAX);
    // Recovered at time zero through the zero deadline; confidence clamps.
    send_sample(3'd1, 1'b1, 16'sh7FFF, 16'sh8000, 16'sd640, 16'sh7FFF, 63'd0);
    send_sample(3'd2, 1'b1, -16'sd5, 16'sd5, 16'sd0, 16'sh8000, 63'd1000);
    // Hold, decay, return to neutral, then rate-limited catch-up.
    send_sample(3'd1, 1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 63'd100000000);
    send_sample(3'd1, 1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 63'd300000000);
    send_sample(3'd1, 1'b1, 16'sd0, 16'sd0, 16'sd0, 16'sd16384, 63'd400000000);
    send_sample(3'd1, 1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 63'd450000000);
    send_sample(3'd1, 1'b1, 16'sh7FFF, 16'sh8000, 16'sd9, 16'sd8000, 63'd650000000);
    send_sample(3'd1, 1'b1, 16'sd7, 16'sd7, 16'sd7, 16'sd8000, 63'd700000000);
    // Time going backward after a hold, and for a missing sample.
    send_sample(3'd2, 1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 63'd500);
    send_sample(3'd2, 1'b1, 16'sd300, 16'sd300, 16'sd300, 16'sd100, 63'd400);
    // Elapsed beyond 2^48 and a deadline that saturates.
    send_sample(3'd3, 1'b1, 16'sd50, -16'sd50, 16'sd1, 16'sd16000, 63'd5);
    send_sample(3'd3, 1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 63'h0002_0000_0000_0000);
    send_sample(3'd3, 1'b1, 16'sh7FFF, 16'sh8000, 16'sd0, 16'sd1, T_MAX);
    send_sample(3'd3, 1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, T_MAX);
    send_sample(3'd3, 1'b1, 16'sd1, 16'sd1, 16'sd1, 16'sd1, T_MAX);
    send_sample(3'd4, 1'b1, 16'sd1234, 16'sd1, -16'sd1, 16'sd16385, 63'd7);
  endtask

  // Random sessions per finger: mostly monotonic time, sometimes a jump back.
  task automatic test_random(int n);
    logic [2:0] fin;
    logic [62:0] t;
    for (int i = 0; i < n; i++) begin
      fin = ($urandom_range(15) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(NF - 1));
      if (fin < NF) begin
        clock_ns[fin] = clock_ns[fin] + rand_advance();
        if (clock_ns[fin][62:60] == 3'b111) clock_ns[fin] = 63'd0;
        t = ($urandom_range(19) == 0) ? 63'({$urandom, $urandom}) : clock_ns[fin];
      end else begin
        t = 63'({$urandom, $urandom});
      end
      send_sample(fin, $urandom_range(99) < 55, rand_angle(), rand_angle(), rand_angle(),
                  ($urandom_range(3) == 0) ? 16'($urandom)
                                           : 16'($urandom_range(16384)), t);
    end
  endtask

  task automatic test_config_sweep(int n_each);
    write_reg(fdr_pkg::REG_HELD_DUR, 32'd0);
    write_reg(fdr_pkg::REG_RET_DUR, 32'd1);
    write_reg(fdr_pkg::REG_REC_DUR, 32'hFFFF_FFFF);
    write_reg(fdr_pkg::REG_DECAY, 32'd65535);
    write_reg(fdr_pkg::REG_REC_RATE, 32'd1);
    test_random(n_each);
    write_reg(fdr_pkg::REG_HELD_DUR, 32'hFFFF_FFFF);
    write_reg(fdr_pkg::REG_RET_DUR, 32'hFFFF_FFFF);
    write_reg(fdr_pkg::REG_REC_DUR, 32'd0);
    write_reg(fdr_pkg::REG_DECAY, 32'd0);
    write_reg(fdr_pkg::REG_REC_RATE, 32'd65535);
    test_random(n_each);
    write_reg(fdr_pkg::REG_HELD_DUR, 32'd50000000);
    write_reg(fdr_pkg::REG_RET_DUR, 32'd0);
    write_reg(fdr_pkg::REG_REC_DUR, 32'd100000000);
    write_reg(fdr_pkg::REG_DECAY, 32'd40000);
    write_reg(fdr_pkg::REG_REC_RATE, 32'd3000);
    test_random(n_each);
    write_reg(fdr_pkg::REG_HELD_DUR, 32'd150000000);
    write_reg(fdr_pkg::REG_RET_DUR, 32'd350000000);
    write_reg(fdr_pkg::REG_REC_DUR, 32'd200000000);
    write_reg(fdr_pkg::REG_DECAY, 32'd13107);
    write_reg(fdr_pkg::REG_REC_RATE, 32'd23040);
  endtask

  initial begin
    model_reset();
    for (int f = 0; f < NF; f++) clock_ns[f] = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_idle_pct = 27; recv_idle_pct = 81;
    test_directed();
    test_random(590);
    send_idle_pct = 81; recv_idle_pct = 27;
    test_config_sweep(250);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random(590);
    in_valid <= 1'b0;
    while (pending_poses.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    $display("Covered %0d observations, %0d results, over four register settings.",
             items_sent, results_seen);
    if (mismatches == 0 && pending_poses.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Worst case: about 2000 items, each with its longest sequence plus stalls.
  initial begin
    #60ms;
    $display("Timeout with %0d results outstanding", pending_poses.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule
